/* src/hss_pkg.sv */
`default_nettype none
// Shared constants for the heat stencil step block: defaults, field widths and register indexes.
package hss_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 24;

    localparam int GRID_WIDTH_W  = 11;
    localparam int GRID_HEIGHT_W = 16;
    localparam int GAIN_W        = 16;
    localparam int GAIN_FRAC     = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_GAIN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZONTAL_GAIN = 2'd3;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 11'd20;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 16'd20;
    localparam logic [GAIN_W-1:0]        GAIN_RST        = 16'd16384;

    localparam int MIN_DIM = 3;

    localparam int OUT_DEPTH = 8;

endpackage
`default_nettype wire

/* src/heat_stencil_step_top.sv */
`default_nettype none
// Top level of the heat stencil step block: line buffers, stencil window, update pipeline, output queue.
//
// The block takes one grid cell per cycle in row-major order and, for every interior cell,
// returns the explicit heat-equation update one row and one column behind the input stream.
// A result passes in turn through the B, C, D and E registers and then the output queue before it
// is presented at the output. The two previous rows sit in two RAMs indexed by column,
// read when an item is accepted and written in the following cycle; a column read that meets
// the write still in flight is forwarded. Input stall rises only when
// results queued or in flight fill the eight-entry output queue, so with an output side that
// keeps up the block sustains one item per cycle. The configuration registers should be
// written only while no item is in flight.
module heat_stencil_step_top
    #(
    parameter int MAX_WIDTH  = hss_pkg::MAX_WIDTH_DEF,
    parameter int DATA_WIDTH = hss_pkg::DATA_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_cfg_wr_en,
    input  wire logic [hss_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [hss_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [DATA_WIDTH-1:0]       i_temperature,
    input  wire logic                               i_start_of_grid,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [DATA_WIDTH-1:0]            o_new_temperature,
    output logic [hss_pkg::GRID_HEIGHT_W-1:0]       o_out_row,
    output logic [COL_W-1:0]                        o_out_col,
    output logic                                    o_last_of_grid
);

    import hss_pkg::*;

    localparam int WCMP_W = (COL_W + 1 > GRID_WIDTH_W) ? COL_W + 1 : GRID_WIDTH_W;
    localparam int ROW_W  = GRID_HEIGHT_W;
    localparam int DIFF_W = DATA_WIDTH + 2;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RES_W  = SUM_W - GAIN_FRAC + 1;
    localparam int PTR_W  = $clog2(OUT_DEPTH);
    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int OCC_W  = CNT_W + 1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] temp;
        t_meta                        meta;
    } t_result;

    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;
    logic [GAIN_W-1:0]        r_vgain;
    logic [GAIN_W-1:0]        r_hgain;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [WCMP_W-1:0] w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [WCMP_W-1:0] a_col_ext;
    logic [WCMP_W-1:0] a_col_inc;
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic              a_fire;
    logic              a_emit;
    t_meta             a_meta;
    logic              n_fwd;

    logic                         r_b_valid;
    logic                         r_b_emit;
    logic signed [DATA_WIDTH-1:0] r_b_cell;
    logic [COL_W-1:0]             r_b_col;
    t_meta                        r_b_meta;
    logic                         r_fwd;
    logic signed [DATA_WIDTH-1:0] r_fwd_cell;
    logic signed [DATA_WIDTH-1:0] r_fwd_above;
    logic signed [DATA_WIDTH-1:0] ram_above_q;
    logic signed [DATA_WIDTH-1:0] ram_two_q;
    logic signed [DATA_WIDTH-1:0] b_above;
    logic signed [DATA_WIDTH-1:0] b_two;
    logic signed [DIFF_W-1:0]     b_dv;
    logic signed [DIFF_W-1:0]     b_dh;

    logic signed [DATA_WIDTH-1:0] r_win_left;
    logic signed [DATA_WIDTH-1:0] r_win_center;
    logic signed [DATA_WIDTH-1:0] r_win_up;
    logic signed [DATA_WIDTH-1:0] r_win_down;

    logic                         r_c_valid;
    logic signed [DIFF_W-1:0]     r_c_dv;
    logic signed [DIFF_W-1:0]     r_c_dh;
    logic signed [DATA_WIDTH-1:0] r_c_center;
    t_meta                        r_c_meta;
    logic signed [PROD_W-1:0]     c_pv;
    logic signed [PROD_W-1:0]     c_ph;

    logic                         r_d_valid;
    logic signed [PROD_W-1:0]     r_d_pv;
    logic signed [PROD_W-1:0]     r_d_ph;
    logic signed [DATA_WIDTH-1:0] r_d_center;
    t_meta                        r_d_meta;

    logic                         r_e_valid;
    logic signed [SUM_W-1:0]      r_e_sum;
    logic signed [DATA_WIDTH-1:0] r_e_center;
    t_meta                        r_e_meta;
    logic signed [RES_W-1:0]      e_res;
    t_result                      e_result;

    t_result          r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [OCC_W-1:0] occ;
    logic             pop;
    t_result          head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_vgain       <= GAIN_RST;
            r_hgain       <= GAIN_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[GRID_WIDTH_W-1:0];
                end
                REG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[GRID_HEIGHT_W-1:0];
                end
                REG_VERTICAL_GAIN: begin
                    r_vgain <= i_cfg_data[GAIN_W-1:0];
                end
                REG_HORIZONTAL_GAIN: begin
                    r_hgain <= i_cfg_data[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective grid size and position of the incoming cell.
    always_comb begin
        if (WCMP_W'(r_grid_width) < WCMP_W'(MIN_DIM)) begin
            w_eff = WCMP_W'(MIN_DIM);
        end else if (WCMP_W'(r_grid_width) > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = WCMP_W'(r_grid_width);
        end
        if (r_grid_height < ROW_W'(MIN_DIM)) begin
            h_eff = ROW_W'(MIN_DIM);
        end else begin
            h_eff = r_grid_height;
        end

        a_col_ext = i_start_of_grid ? '0 : WCMP_W'(r_col);
        if (a_col_ext >= w_eff) begin
            a_col_ext = '0;
        end
        a_row = i_start_of_grid ? '0 : r_row;
        if (a_row >= h_eff) begin
            a_row = '0;
        end
        a_col     = a_col_ext[COL_W-1:0];
        a_col_inc = a_col_ext + WCMP_W'(1);
        a_emit    = (a_row >= ROW_W'(2)) && (a_col_ext >= WCMP_W'(2));

        a_meta.row  = a_row - ROW_W'(1);
        a_meta.col  = a_col - COL_W'(1);
        a_meta.last = (a_row == h_eff - ROW_W'(1)) && (a_col_ext == w_eff - WCMP_W'(1));

        if (a_col_inc >= w_eff) begin
            n_col = '0;
            n_row = (a_row + ROW_W'(1) >= h_eff) ? '0 : a_row + ROW_W'(1);
        end else begin
            n_col = a_col_inc[COL_W-1:0];
            n_row = a_row;
        end
    end

    assign a_fire = i_in_valid && !o_in_stall;
    assign n_fwd  = a_fire && r_b_valid && (r_b_col == a_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_b_emit  <= 1'b0;
            r_fwd     <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (a_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_b_valid <= a_fire;
            r_b_emit  <= a_fire && a_emit;
            r_fwd     <= n_fwd;
            r_c_valid <= r_b_valid && r_b_emit;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    hss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_col),
        .i_wr_data (r_b_cell),
        .i_rd_addr (a_col),
        .o_rd_data (ram_above_q)
    );

    hss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_WIDTH)
    ) u_row_two_above (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_col),
        .i_wr_data (b_above),
        .i_rd_addr (a_col),
        .o_rd_data (ram_two_q)
    );

    assign b_above = r_fwd ? r_fwd_cell : ram_above_q;
    assign b_two   = r_fwd ? r_fwd_above : ram_two_q;

    assign b_dv = DIFF_W'(r_win_up) + DIFF_W'(r_win_down) - (DIFF_W'(r_win_center) <<< 1);
    assign b_dh = DIFF_W'(r_win_left) + DIFF_W'(b_above) - (DIFF_W'(r_win_center) <<< 1);

    assign c_pv = $signed({1'b0, r_vgain}) * r_c_dv;
    assign c_ph = $signed({1'b0, r_hgain}) * r_c_dh;

    always_comb begin
        e_res = RES_W'(r_e_center) + RES_W'($signed(r_e_sum[SUM_W-1:GAIN_FRAC]));
        if (&e_res[RES_W-1:DATA_WIDTH-1] || ~|e_res[RES_W-1:DATA_WIDTH-1]) begin
            e_result.temp = e_res[DATA_WIDTH-1:0];
        end else if (e_res[RES_W-1]) begin
            e_result.temp = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            e_result.temp = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        e_result.meta = r_e_meta;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_b_cell    <= i_temperature;
        r_b_col     <= a_col;
        r_b_meta    <= a_meta;
        r_fwd_cell  <= r_b_cell;
        r_fwd_above <= b_above;

        if (r_b_valid) begin
            r_win_left   <= r_win_center;
            r_win_center <= b_above;
            r_win_up     <= b_two;
            r_win_down   <= r_b_cell;
        end

        r_c_dv     <= b_dv;
        r_c_dh     <= b_dh;
        r_c_center <= r_win_center;
        r_c_meta   <= r_b_meta;

        r_d_pv     <= c_pv;
        r_d_ph     <= c_ph;
        r_d_center <= r_c_center;
        r_d_meta   <= r_c_meta;

        r_e_sum    <= SUM_W'(r_d_pv) + SUM_W'(r_d_ph) + SUM_W'(1 << (GAIN_FRAC - 1));
        r_e_center <= r_d_center;
        r_e_meta   <= r_d_meta;

        if (r_e_valid) begin
            r_fifo[r_wr_ptr] <= e_result;
        end
    end

    // Output queue; results in flight are counted so that a push never meets a full queue.
    assign pop     = o_out_valid && !i_out_stall;
    assign n_count = r_count + CNT_W'(r_e_valid) - CNT_W'(pop);
    assign occ     = OCC_W'(r_count) + OCC_W'(r_b_valid && r_b_emit) + OCC_W'(r_c_valid)
                     + OCC_W'(r_d_valid) + OCC_W'(r_e_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_e_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign head              = r_fifo[r_rd_ptr];
    assign o_in_stall        = occ >= OCC_W'(OUT_DEPTH);
    assign o_out_valid       = r_count != '0;
    assign o_new_temperature = head.temp;
    assign o_out_row         = head.meta.row;
    assign o_out_col         = head.meta.col;
    assign o_last_of_grid    = head.meta.last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_DEPTH))
        else $error("output queue count beyond its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_count < CNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_b_valid) && r_b_valid)
        else $error("line buffer forwarding without a write in flight");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_c_meta.row != '0) && (r_c_meta.col != '0))
        else $error("boundary cell entered the update pipeline");
`endif

endmodule
`default_nettype wire

/* src/hss_ram.sv */
`default_nettype none
// Generic single-port-write, single-port-read RAM with a registered read.
module hss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the heat stencil step block: directed grids, random traffic, back-pressure.
module tb_top;
    import hss_pkg::*;

    localparam int NCOLS        = MAX_WIDTH_DEF;
    localparam int QUIET_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TEMP_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] temp;
        logic [15:0]        row;
        logic [9:0]         col;
        logic               last;
    } t_cell_update;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [23:0] i_temperature = '0;
    logic i_start_of_grid = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [23:0] o_new_temperature;
    logic [15:0] o_out_row;
    logic [9:0] o_out_col;
    logic o_last_of_grid;

    // Predicted state of the block.
    logic [10:0] cfg_width = GRID_WIDTH_RST;
    logic [15:0] cfg_height = GRID_HEIGHT_RST;
    logic [15:0] cfg_vgain = GAIN_RST;
    logic [15:0] cfg_hgain = GAIN_RST;
    logic signed [23:0] line_above [NCOLS] = '{default: '0};
    logic signed [23:0] line_two_above [NCOLS] = '{default: '0};
    logic signed [23:0] stencil_win [4] = '{default: '0};
    int line_writes [NCOLS] = '{default: 0};
    int col_cnt = 0;
    int row_cnt = 0;

    t_cell_update pending_updates[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    heat_stencil_step_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_temperature     (i_temperature),
        .i_start_of_grid   (i_start_of_grid),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_new_temperature (o_new_temperature),
        .o_out_row         (o_out_row),
        .o_out_col         (o_out_col),
        .o_last_of_grid    (o_last_of_grid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_width();
        int w;
        w = cfg_width;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > NCOLS) w = NCOLS;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = cfg_height;
        if (h < MIN_DIM) h = MIN_DIM;
        return h;
    endfunction

    // True when both line buffers hold written data across the current width.
    function automatic bit lines_ready();
        int w;
        w = eff_width();
        for (int c = 0; c < w; c++) begin
            if (line_writes[c] < 2) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_cell(input logic signed [23:0] temp, input logic sog);
        int w, h;
        longint above, two, left, center, right, up, down, acc, res;
        t_cell_update upd;
        w = eff_width();
        h = eff_height();
        if (sog) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        above  = line_above[col_cnt];
        two    = line_two_above[col_cnt];
        left   = stencil_win[0];
        center = stencil_win[1];
        right  = above;
        up     = stencil_win[2];
        down   = stencil_win[3];
        if (row_cnt >= 2 && col_cnt >= 2) begin
            acc = longint'(cfg_vgain) * (up + down - 2 * center)
                + longint'(cfg_hgain) * (left + right - 2 * center) + 32768;
            res = center + (acc >>> 16);
            if (res > longint'(TEMP_MAX)) res = TEMP_MAX;
            if (res < longint'(TEMP_MIN)) res = TEMP_MIN;
            upd.temp = res[23:0];
            upd.row  = 16'(row_cnt - 1);
            upd.col  = 10'(col_cnt - 1);
            upd.last = (row_cnt == h - 1) && (col_cnt == w - 1);
            pending_updates.push_back(upd);
        end
        stencil_win[0] = stencil_win[1];
        stencil_win[1] = above[23:0];
        stencil_win[2] = two[23:0];
        stencil_win[3] = temp;
        line_two_above[col_cnt] = above[23:0];
        line_above[col_cnt] = temp;
        if (line_writes[col_cnt] < 2) line_writes[col_cnt]++;
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task automatic send_cell(input logic signed [23:0] temp, input logic sog);
        int gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 60) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_temperature <= temp;
        i_start_of_grid <= sog;
        do @(posedge i_clk); while (o_in_stall);
        predict_cell(temp, sog);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [15:0] width_raw, input logic [15:0] height_raw,
                             input logic [15:0] vgain, input logic [15:0] hgain);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_data <= width_raw;
        @(posedge i_clk);
        i_cfg_index <= REG_GRID_HEIGHT;
        i_cfg_data <= height_raw;
        @(posedge i_clk);
        i_cfg_index <= REG_VERTICAL_GAIN;
        i_cfg_data <= vgain;
        @(posedge i_clk);
        i_cfg_index <= REG_HORIZONTAL_GAIN;
        i_cfg_data <= hgain;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width = width_raw[10:0];
        cfg_height = height_raw;
        cfg_vgain = vgain;
        cfg_hgain = hgain;
    endtask

    function automatic logic signed [23:0] rand_temp();
        int pick;
        logic signed [23:0] v;
        pick = $urandom_range(9);
        if (pick < 5) begin
            v = 24'($urandom);
        end else if (pick < 8) begin
            v = 24'($urandom_range(8192));
            v = v - 24'sd4096;
        end else if (pick == 8) begin
            v = TEMP_MAX;
        end else begin
            v = TEMP_MIN;
        end
        return v;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(32768));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Receiver stall: a requested long hold-off takes precedence over random stalling.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_cell_update exp_upd;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_updates.size() == 0) begin
                report_mismatch($sformatf("unexpected result at (%0d,%0d) value %0d",
                                          o_out_row, o_out_col, o_new_temperature));
            end else begin
                exp_upd = pending_updates.pop_front();
                if (o_new_temperature !== exp_upd.temp)
                    report_mismatch($sformatf("new_temperature at (%0d,%0d): expected %0d, got %0d",
                                              exp_upd.row, exp_upd.col, exp_upd.temp,
                                              o_new_temperature));
                if (o_out_row !== exp_upd.row)
                    report_mismatch($sformatf("out_row: expected %0d, got %0d",
                                              exp_upd.row, o_out_row));
                if (o_out_col !== exp_upd.col)
                    report_mismatch($sformatf("out_col: expected %0d, got %0d",
                                              exp_upd.col, o_out_col));
                if (o_last_of_grid !== exp_upd.last)
                    report_mismatch($sformatf("last_of_grid at (%0d,%0d): expected %0b, got %0b",
                                              exp_upd.row, exp_upd.col, exp_upd.last,
                                              o_last_of_grid));
            end
        end
    end

    // Two 4 by 3 grids: saturation at both ends, then ties that round upwards.
    // The second grid follows without a start marker.
    task automatic test_directed_cases();
        logic signed [23:0] cells [24];
        cells = '{24'sd0, TEMP_MAX, TEMP_MIN, 24'sd0,
                  TEMP_MAX, TEMP_MIN, TEMP_MAX, TEMP_MIN,
                  24'sd0, TEMP_MAX, TEMP_MIN, 24'sd0,
                  24'sd0, 24'sd1, -24'sd1, 24'sd0,
                  24'sd0, 24'sd0, 24'sd0, 24'sd0,
                  24'sd0, 24'sd0, 24'sd0, 24'sd0};
        send_idle_pct = 0;
        stall_pct = 0;
        write_cfg(16'hF804, 16'd3, 16'd32768, 16'd32768);
        for (int i = 0; i < 24; i++) send_cell(cells[i], i == 0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_cfg(16'd10, 16'd8, rand_gain(), rand_gain());
        hold_token <= hold_token + 1;
        for (int i = 0; i < 80; i++) send_cell(rand_temp(), i == 0);
        wait_idle();
    endtask

    task automatic run_random_traffic(input int n_items);
        int sent, kind, len;
        logic [15:0] w_raw, h_raw;
        logic first_sog, sog, cfg_new;
        sent = 0;
        while (sent < n_items) begin
            cfg_new = 1'b0;
            if ($urandom_range(99) < 35) begin
                wait_idle();
                case ($urandom_range(9))
                    0: w_raw = 16'($urandom_range(2));
                    1: w_raw = 16'($urandom_range(1025, 65535));
                    default: w_raw = 16'($urandom_range(3, 12));
                endcase
                case ($urandom_range(9))
                    0: h_raw = 16'($urandom_range(2));
                    1: h_raw = 16'hFFFF;
                    2: h_raw = 16'($urandom_range(9, 65535));
                    default: h_raw = 16'($urandom_range(3, 8));
                endcase
                write_cfg(w_raw, h_raw, rand_gain(), rand_gain());
                cfg_new = 1'b1;
            end
            kind = $urandom_range(99);
            len = eff_width() * eff_height();
            first_sog = (kind < 55);
            if (kind >= 70 && kind < 85) begin
                first_sog = 1'b1;
                len = $urandom_range(1, len);
            end
            if (len > 150) len = $urandom_range(10, 150);
            if (len > n_items - sent) len = n_items - sent;
            for (int i = 0; i < len; i++) begin
                if (kind >= 85) sog = ($urandom_range(9) == 0);
                else sog = (i == 0) && first_sog;
                // A grid that continues into columns never written must restart instead.
                if (i == 0 && cfg_new && !lines_ready()) sog = 1'b1;
                send_cell(rand_temp(), sog);
            end
            sent += len;
        end
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        run_random_traffic(210);
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 82;
        stall_pct = 0;
        run_random_traffic(210);
    endtask

    task automatic test_receiver_idle();
        send_idle_pct = 0;
        stall_pct = 82;
        run_random_traffic(210);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 30;
        stall_pct = 30;
        run_random_traffic(210);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_backpressure();
        test_no_idle();
        test_sender_idle();
        test_receiver_idle();
        test_both_idle();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
